>>> src/mlpq_pkg.sv
// mlpq_pkg: shared types, codes and default sizes for the multilevel priority fifo
// used by the sequencer and the top level; depends on nothing

`timescale 1ns / 1ps

package mlpq_pkg;

   // default sizes
   localparam int DEF_CAPACITY   = 32;
   localparam int DEF_MAX_LEVELS = 8;

   // fixed field widths
   localparam int TAG_W    = 16;
   localparam int LEVEL_W  = 4;
   localparam int POS_W    = 6;
   localparam int TOTAL_W  = 6;
   localparam int STATUS_W = 3;
   localparam int KIND_W   = 2;

   // level_count value after reset
   localparam int RESET_LEVELS = 8;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BADLEVEL = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [LEVEL_W-1:0] push_level;
      logic [TAG_W-1:0]   push_tag;
      logic [POS_W-1:0]   remove_position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    out_tag;
      logic [LEVEL_W-1:0]  out_level;
      logic [TOTAL_W-1:0]  entry_total;
   } rsp_type;

   // one stored entry
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // top level to sequencer
   typedef struct packed {
      logic start;
      logic cfg_clear;
      logic out_ready;
   } seq_ctl_type;

   // sequencer to top level
   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

endpackage

>>> src/mlpq_ram.sv
// mlpq_ram: generic single-write, single-read ram with registered read data
// no dependencies

`timescale 1ns / 1ps

module mlpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/mlpq_seq.sv
// mlpq_seq: sequencer that walks the sorted entry ram one slot per step
// depends on mlpq_pkg; drives one mlpq_ram instance through its port

`timescale 1ns / 1ps

module mlpq_seq import mlpq_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  seq_ctl_type                 ctl,
   input  req_type                     req,
   input  logic [LEVEL_W-1:0]          level_count,
   output seq_stat_type                stat,
   output rsp_type                     result,
   output logic                        ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
   output logic [ENTRY_W-1:0]          ram_wr_data,
   output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
   input  logic [ENTRY_W-1:0]          ram_rd_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_P_READ  = 3'd1;
   localparam logic [2:0] S_P_CHECK = 3'd2;
   localparam logic [2:0] S_P_PLACE = 3'd3;
   localparam logic [2:0] S_R_READ  = 3'd4;
   localparam logic [2:0] S_R_USE   = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             first_ff, first_in;
   entry_type        pend_ff, pend_in;
   rsp_type          res_ff, res_in;

   logic [CNT_W-1:0] count_m1;
   logic [IDX_W-1:0] last_idx;
   logic [POS_W-1:0] pos_m1;
   logic             pos_bad;
   logic             level_bad;
   logic             is_full;
   entry_type        rd_entry;
   logic             moves_up;

   assign count_m1  = count_ff - 1'b1;
   assign last_idx  = IDX_W'(count_m1);
   assign pos_m1    = req.remove_position - 1'b1;
   assign pos_bad   = (req.remove_position == '0) ||
                      (CMP_W'(req.remove_position) > CMP_W'(count_ff));
   assign level_bad = (req.push_level == '0) || (req.push_level > level_count);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign rd_entry  = entry_type'(ram_rd_data);

   // push compare: the entry read stays behind the new one when its level is lower
   assign moves_up  = (rd_entry.level < pend_ff.level);

   assign ram_rd_addr = idx_ff;

   // next state, ram write and result building
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      pend_in     = pend_ff;
      res_in      = res_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = pend_ff;
      stat.busy   = (state_ff != S_IDLE);
      stat.done   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (ctl.cfg_clear) begin
               count_in = '0;
            end
            if (ctl.start) begin
               res_in.status    = STAT_OK;
               res_in.out_tag   = '0;
               res_in.out_level = '0;
               pend_in.level    = req.push_level;
               pend_in.tag      = req.push_tag;
               first_in         = 1'b1;
               state_in         = S_FINISH;
               case (req.kind)
                  KIND_PUSH: begin
                     if (level_bad) begin
                        res_in.status = STAT_BADLEVEL;
                     end else if (is_full) begin
                        res_in.status = STAT_FULL;
                     end else if (count_ff == '0) begin
                        idx_in   = '0;
                        state_in = S_P_PLACE;
                     end else begin
                        idx_in   = last_idx;
                        state_in = S_P_READ;
                     end
                  end
                  KIND_REMOVE: begin
                     if (pos_bad) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        idx_in   = IDX_W'(pos_m1);
                        state_in = S_R_READ;
                     end
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_R_READ;
                     end
                  end
                  default: begin
                     count_in      = '0;
                     res_in.status = STAT_CLEARED;
                  end
               endcase
            end
         end

         // push: walk down from the tail, moving lower levels up one slot
         S_P_READ: begin
            state_in = S_P_CHECK;
         end
         S_P_CHECK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff + 1'b1;
            if (moves_up) begin
               ram_wr_data = rd_entry;
               if (idx_ff == '0) begin
                  state_in = S_P_PLACE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_P_READ;
               end
            end else begin
               ram_wr_data = pend_ff;
               count_in    = count_ff + 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_P_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = pend_ff;
            count_in    = count_ff + 1'b1;
            state_in    = S_FINISH;
         end

         // remove: take the target, then move later entries down one slot
         S_R_READ: begin
            state_in = S_R_USE;
         end
         S_R_USE: begin
            if (first_ff) begin
               res_in.out_tag   = rd_entry.tag;
               res_in.out_level = rd_entry.level;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_ff - 1'b1;
               ram_wr_data = rd_entry;
            end
            first_in = 1'b0;
            if (idx_ff == last_idx) begin
               count_in = count_m1;
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_R_READ;
            end
         end

         // hand the result over once the output register can take it
         S_FINISH: begin
            res_in.entry_total = TOTAL_W'(count_ff);
            if (ctl.out_ready) begin
               stat.done = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result    = res_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      first_ff <= first_in;
      pend_ff  <= pend_in;
      res_ff   <= res_in;
   end

endmodule

>>> src/multilevel_priority_fifo.sv
// multilevel_priority_fifo: top level with level register, output register and store
// depends on mlpq_pkg, mlpq_seq and mlpq_ram
// throughput: one item at a time; the next transfer is taken the cycle after the result loads,
// a stalled result holds the sequencer; set by the single ram port walked one slot per step
// reset: synchronous, active high; store empty, level_count 8 (capped at MAX_LEVELS)

`timescale 1ns / 1ps

module multilevel_priority_fifo import mlpq_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [LEVEL_W-1:0] csr_wdata
);

   localparam logic [LEVEL_W-1:0] MAX_LVL   = LEVEL_W'(MAX_LEVELS);
   localparam logic [LEVEL_W-1:0] RESET_LVL =
      LEVEL_W'((RESET_LEVELS > MAX_LEVELS) ? MAX_LEVELS : RESET_LEVELS);
   localparam int IDX_W = $clog2(CAPACITY);

   logic [LEVEL_W-1:0] level_count_ff, level_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   seq_ctl_type        ctl;
   seq_stat_type       stat;
   rsp_type            result;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // level register write with clamping
   always_comb begin
      level_count_in = level_count_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            level_count_in = LEVEL_W'(1);
         end else if (csr_wdata > MAX_LVL) begin
            level_count_in = MAX_LVL;
         end else begin
            level_count_in = csr_wdata;
         end
      end
   end

   // handshake to the sequencer
   assign req_stall     = stat.busy;
   assign ctl.start     = req_valid && !stat.busy;
   assign ctl.cfg_clear = csr_we;
   assign ctl.out_ready = !rsp_valid_ff || !rsp_stall;

   // output register: loads on finish, drops after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= RESET_LVL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         level_count_ff <= level_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer
   mlpq_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req         (req_data),
      .level_count (level_count_ff),
      .stat        (stat),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // sorted entry store
   mlpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> tb/sv/tb_multilevel_priority_fifo.sv
// tb_multilevel_priority_fifo: self-checking testbench for the multilevel priority fifo
// keeps a sorted entry list to predict every result; random idling on both channels
// depends on mlpq_pkg and multilevel_priority_fifo

`timescale 1ns / 1ps

module tb_multilevel_priority_fifo;
   import mlpq_pkg::*;

   // run control
   localparam int SETTLE_CYCLES = 2 * DEF_CAPACITY + 8;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_AT       = 120;
   localparam int HOLD_CYCLES   = 250;
   localparam int FAIL_PRINTS   = 50;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [LEVEL_W-1:0]   csr_wdata = '0;

   // operations waiting to be offered, results waiting to arrive
   req_type              queued_ops[$];
   rsp_type              due_results[$];

   // predicted store: entries sorted by level, oldest first within a level
   entry_type            model_entries[$];
   logic [LEVEL_W-1:0]   model_levels;

   // count mirror used only to aim positions and levels while generating
   int                   plan_count;
   int                   plan_levels;

   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   fail_count    = 0;
   int                   results_seen  = 0;
   int                   hold_left     = 0;
   int                   quiet_cycles  = 0;

   multilevel_priority_fifo u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // level register value as the block takes it
   function automatic int clamp_levels(int v);
      if (v < 1) return 1;
      if (v > DEF_MAX_LEVELS) return DEF_MAX_LEVELS;
      return v;
   endfunction

   // expected result of one operation, updates the predicted store
   function automatic rsp_type apply_queue_op(req_type op);
      rsp_type   res;
      entry_type ent;
      int        at;
      int        pos;
      res = '0;
      res.status = STAT_OK;
      pos = op.remove_position;
      case (op.kind)
         KIND_PUSH: begin
            if (op.push_level == 0 || op.push_level > model_levels) begin
               res.status = STAT_BADLEVEL;
            end else if (model_entries.size() >= DEF_CAPACITY) begin
               res.status = STAT_FULL;
            end else begin
               // behind every entry of the same or a more urgent level
               at = 0;
               while (at < model_entries.size() && model_entries[at].level >= op.push_level)
                  at++;
               ent.level = op.push_level;
               ent.tag   = op.push_tag;
               model_entries.insert(at, ent);
            end
         end
         KIND_REMOVE: begin
            if (pos < 1 || pos > model_entries.size()) begin
               res.status = STAT_EMPTY;
            end else begin
               ent = model_entries[pos - 1];
               model_entries.delete(pos - 1);
               res.out_tag   = ent.tag;
               res.out_level = ent.level;
            end
         end
         KIND_POP: begin
            if (model_entries.size() == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               ent = model_entries.pop_front();
               res.out_tag   = ent.tag;
               res.out_level = ent.level;
            end
         end
         default: begin
            model_entries.delete();
            res.status = STAT_CLEARED;
         end
      endcase
      res.entry_total = TOTAL_W'(model_entries.size());
      return res;
   endfunction

   // queue one operation and track the entry count it leaves
   function automatic void add_op(logic [KIND_W-1:0] kind, int level, int tag, int pos);
      req_type op;
      op.kind            = kind;
      op.push_level      = LEVEL_W'(level);
      op.push_tag        = TAG_W'(tag);
      op.remove_position = POS_W'(pos);
      queued_ops.push_back(op);
      case (kind)
         KIND_PUSH:
            if (level >= 1 && level <= plan_levels && plan_count < DEF_CAPACITY) plan_count++;
         KIND_REMOVE:
            if (pos >= 1 && pos <= plan_count) plan_count--;
         KIND_POP:
            if (plan_count > 0) plan_count--;
         default:
            plan_count = 0;
      endcase
   endfunction

   // random operations, alternating fill and drain stretches
   task automatic add_random_ops(int n);
      int                roll;
      int                level;
      int                tag;
      int                pos;
      bit                filling;
      logic [KIND_W-1:0] kind;
      for (int i = 0; i < n; i++) begin
         filling = ((i / 80) % 2) == 0;
         roll    = $urandom_range(0, 99);
         level   = $urandom_range(0, 15);
         tag     = $urandom_range(0, 65535);
         pos     = $urandom_range(0, 63);
         if (roll < 2)
            kind = KIND_CLEAR;
         else if (filling ? (roll < 85) : (roll < 17))
            kind = KIND_PUSH;
         else if ($urandom_range(0, 1) == 1)
            kind = KIND_POP;
         else
            kind = KIND_REMOVE;
         // mostly legal levels and positions, some out of range
         if (kind == KIND_PUSH) begin
            if ($urandom_range(0, 99) < 92)
               level = $urandom_range(1, plan_levels);
            else if ($urandom_range(0, 1) == 1)
               level = 0;
            else
               level = $urandom_range(plan_levels + 1, 15);
         end else if (kind == KIND_REMOVE) begin
            if (plan_count > 0 && $urandom_range(0, 99) < 88)
               pos = $urandom_range(1, plan_count);
            else if ($urandom_range(0, 1) == 1)
               pos = 0;
            else
               pos = $urandom_range(plan_count + 1, 63);
         end
         add_op(kind, level, tag, pos);
      end
   endtask

   // sender pauses until every result is in and the block has settled
   task automatic wait_idle();
      while (queued_ops.size() != 0 || req_valid || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // level register write, only while idle
   task automatic write_levels(int v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v[LEVEL_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      plan_levels = clamp_levels(v & 15);
      plan_count  = 0;
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         if (fail_count < FAIL_PRINTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // request side: predict on each transfer, then offer the next operation
   always @(posedge clock) begin : drive_ops
      rsp_type due;
      if (reset) begin
         model_entries.delete();
         model_levels = LEVEL_W'(clamp_levels(RESET_LEVELS));
         req_valid <= 1'b0;
      end else begin
         // a level write empties the store while the block is idle
         if (csr_we) begin
            model_levels = LEVEL_W'(clamp_levels(csr_wdata));
            model_entries.delete();
         end
         if (req_valid && !req_stall) begin
            due = apply_queue_op(req_data);
            due_results.push_back(due);
         end
         // hold a stalled payload, otherwise offer or idle
         if (!req_valid || !req_stall) begin
            if (queued_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= queued_ops.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: compare each transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (results_seen == HOLD_AT)
               hold_left = HOLD_CYCLES;
            if (due_results.size() == 0) begin
               if (fail_count < FAIL_PRINTS)
                  $display("%0t: result with nothing due, expected none, got %h",
                           $time, rsp_data);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("out_tag", want.out_tag, rsp_data.out_tag);
               check_field("out_level", want.out_level, rsp_data.out_level);
               check_field("entry_total", want.entry_total, rsp_data.entry_total);
            end
         end
         // one long hold-off so the block backs up, else random stalls
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("multilevel_priority_fifo verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus phases
   initial begin : run_phases
      plan_levels = clamp_levels(RESET_LEVELS);
      plan_count  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_idle_pct = 72;

      // directed: empty store, level limits, tag extremes, ordering, positions, clear
      add_op(KIND_POP, 0, 16'hFFFF, 63);
      add_op(KIND_REMOVE, 15, 0, 1);
      add_op(KIND_PUSH, 0, 16'h5A5A, 0);
      add_op(KIND_PUSH, 15, 16'h1111, 63);
      add_op(KIND_PUSH, 9, 16'h2222, 1);
      add_op(KIND_PUSH, 1, 16'h0000, 63);
      add_op(KIND_PUSH, 8, 16'hFFFF, 0);
      add_op(KIND_PUSH, 1, 16'h1234, 21);
      add_op(KIND_PUSH, 4, 16'hA5A5, 42);
      add_op(KIND_PUSH, 8, 16'h8001, 5);
      add_op(KIND_REMOVE, 0, 16'hFFFF, 0);
      add_op(KIND_REMOVE, 0, 0, 63);
      add_op(KIND_REMOVE, 8, 0, 6);
      add_op(KIND_REMOVE, 0, 0, 5);
      add_op(KIND_REMOVE, 0, 0, 2);
      add_op(KIND_POP, 15, 16'hFFFF, 0);
      add_op(KIND_POP, 0, 0, 0);
      add_op(KIND_POP, 0, 0, 0);
      add_op(KIND_POP, 0, 0, 1);
      add_op(KIND_PUSH, 3, 16'h7E7E, 0);
      add_op(KIND_CLEAR, 15, 16'hFFFF, 63);
      add_op(KIND_CLEAR, 0, 0, 0);
      add_op(KIND_POP, 0, 0, 0);
      wait_idle();

      // top value above the level limit saturates
      write_levels(15);
      add_random_ops(350);
      wait_idle();

      send_idle_pct = 72;
      recv_idle_pct = 12;

      // zero is taken as a single level
      write_levels(0);
      add_random_ops(150);
      wait_idle();

      write_levels($urandom_range(2, 7));
      add_random_ops(250);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;

      write_levels(DEF_MAX_LEVELS);
      add_random_ops(250);
      wait_idle();

      write_levels(1);
      add_random_ops(60);
      wait_idle();

      if (fail_count == 0)
         $display("multilevel_priority_fifo verification clean");
      else
         $display("multilevel_priority_fifo verification failed");
      $finish;
   end

endmodule
